### sv/dtcd_pkg.sv
// ----------------------------------------------------------------------------
// dtcd_pkg: shared types and constants for the day-count to date converter
// Widths, calendar constants and the controller-to-datapath command word.
// ----------------------------------------------------------------------------
package dtcd_pkg;

    // Field widths
    localparam int DAY_BITS   = 20;
    localparam int YEAR_BITS  = 13;
    localparam int MONTH_BITS = 4;
    localparam int DOM_BITS   = 5;

    // Working remainder: day count plus the offset to 0000-03-01
    localparam int REM_BITS  = 21;
    localparam int DOY_BITS  = 9;
    localparam int STEP_BITS = 3;

    // Restoring division steps for 400-year eras and 4-year blocks
    localparam int ERA_STEPS  = 4;
    localparam int QUAD_STEPS = 5;

    // Days from 0000-03-01 to 1970-01-01
    localparam int EPOCH_OFFSET  = 719468;
    localparam int DAYS_PER_ERA  = 146097;
    localparam int DAYS_PER_CENT = 36524;
    localparam int DAYS_PER_QUAD = 1461;
    localparam int DAYS_PER_YEAR = 365;
    localparam int YEARS_PER_ERA = 400;

    localparam int MONTHS = 12;
    // Index of January in the March-based month order
    localparam int MP_JANUARY = 10;

    // First day of each month within a March-based year
    localparam logic [DOY_BITS-1:0] MONTH_START [MONTHS] = '{
        9'd0,   9'd31,  9'd61,  9'd92,  9'd122, 9'd153,
        9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
    };

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_ERA,
        OP_CENT,
        OP_QUAD,
        OP_YEAR,
        OP_MONTH
    } t_dp_op;

    typedef struct packed {
        t_dp_op                 op;
        logic [STEP_BITS-1:0]   step;
    } t_dp_cmd;

endpackage

### sv/dtcd_datapath.sv
// ----------------------------------------------------------------------------
// dtcd_datapath: remainder and year registers of the date converter
// Peels eras, centuries, 4-year blocks, years and months off the day count.
// ----------------------------------------------------------------------------
module dtcd_datapath (
    input  logic                            i_clk,
    input  dtcd_pkg::t_dp_cmd               i_cmd,
    input  logic [dtcd_pkg::DAY_BITS-1:0]   i_day_count,
    output logic [dtcd_pkg::YEAR_BITS-1:0]  o_year,
    output logic [dtcd_pkg::MONTH_BITS-1:0] o_month,
    output logic [dtcd_pkg::DOM_BITS-1:0]   o_day_of_month
);
    import dtcd_pkg::*;

    logic [REM_BITS-1:0]   r_rem,   n_rem;
    logic [YEAR_BITS-1:0]  r_year,  n_year;
    logic [YEAR_BITS-1:0]  r_o_year,  n_o_year;
    logic [MONTH_BITS-1:0] r_o_month, n_o_month;
    logic [DOM_BITS-1:0]   r_o_dom,   n_o_dom;

    logic [REM_BITS-1:0]  era_days;
    logic [REM_BITS-1:0]  quad_days;
    logic [DOY_BITS-1:0]  doy;
    logic [3:0]           mp;
    logic [DOY_BITS-1:0]  dom0;

    assign era_days  = REM_BITS'(DAYS_PER_ERA)  << i_cmd.step[1:0];
    assign quad_days = REM_BITS'(DAYS_PER_QUAD) << i_cmd.step;
    assign doy       = r_rem[DOY_BITS-1:0];

    // Month search over the March-based start table
    always_comb begin
        mp = 4'd0;
        for (int i = 1; i < MONTHS; i++) begin
            if (doy >= MONTH_START[i]) begin
                mp = 4'(i);
            end
        end
        dom0 = doy - MONTH_START[mp] + DOY_BITS'(1);
    end

    always_comb begin
        n_rem     = r_rem;
        n_year    = r_year;
        n_o_year  = r_o_year;
        n_o_month = r_o_month;
        n_o_dom   = r_o_dom;
        unique case (i_cmd.op)
            OP_NOP: begin
            end
            OP_LOAD: begin
                n_rem  = REM_BITS'(i_day_count) + REM_BITS'(EPOCH_OFFSET);
                n_year = '0;
            end
            OP_ERA: begin
                if (r_rem >= era_days) begin
                    n_rem  = r_rem - era_days;
                    n_year = r_year + (YEAR_BITS'(YEARS_PER_ERA) << i_cmd.step[1:0]);
                end
            end
            OP_CENT: begin
                // the last day of an era stays in the fourth century
                priority if (r_rem >= REM_BITS'(3 * DAYS_PER_CENT)) begin
                    n_rem  = r_rem - REM_BITS'(3 * DAYS_PER_CENT);
                    n_year = r_year + YEAR_BITS'(300);
                end else if (r_rem >= REM_BITS'(2 * DAYS_PER_CENT)) begin
                    n_rem  = r_rem - REM_BITS'(2 * DAYS_PER_CENT);
                    n_year = r_year + YEAR_BITS'(200);
                end else if (r_rem >= REM_BITS'(DAYS_PER_CENT)) begin
                    n_rem  = r_rem - REM_BITS'(DAYS_PER_CENT);
                    n_year = r_year + YEAR_BITS'(100);
                end
            end
            OP_QUAD: begin
                if (r_rem >= quad_days) begin
                    n_rem  = r_rem - quad_days;
                    n_year = r_year + (YEAR_BITS'(4) << i_cmd.step);
                end
            end
            OP_YEAR: begin
                // leap day of a block stays in its fourth year
                priority if (r_rem >= REM_BITS'(3 * DAYS_PER_YEAR)) begin
                    n_rem  = r_rem - REM_BITS'(3 * DAYS_PER_YEAR);
                    n_year = r_year + YEAR_BITS'(3);
                end else if (r_rem >= REM_BITS'(2 * DAYS_PER_YEAR)) begin
                    n_rem  = r_rem - REM_BITS'(2 * DAYS_PER_YEAR);
                    n_year = r_year + YEAR_BITS'(2);
                end else if (r_rem >= REM_BITS'(DAYS_PER_YEAR)) begin
                    n_rem  = r_rem - REM_BITS'(DAYS_PER_YEAR);
                    n_year = r_year + YEAR_BITS'(1);
                end
            end
            OP_MONTH: begin
                // January and February belong to the next calendar year
                if (mp >= 4'(MP_JANUARY)) begin
                    n_o_year  = r_year + YEAR_BITS'(1);
                    n_o_month = mp - 4'(MP_JANUARY - 1);
                end else begin
                    n_o_year  = r_year;
                    n_o_month = mp + 4'd3;
                end
                n_o_dom = dom0[DOM_BITS-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rem     <= n_rem;
        r_year    <= n_year;
        r_o_year  <= n_o_year;
        r_o_month <= n_o_month;
        r_o_dom   <= n_o_dom;
    end

    assign o_year         = r_o_year;
    assign o_month        = r_o_month;
    assign o_day_of_month = r_o_dom;

endmodule

### sv/dtcd_ctrl.sv
// ----------------------------------------------------------------------------
// dtcd_ctrl: sequencer of the date converter
// Steps the datapath through each reduction and owns both handshakes.
// ----------------------------------------------------------------------------
module dtcd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output dtcd_pkg::t_dp_cmd o_cmd
);
    import dtcd_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ERA   = 6'b000010,
        S_CENT  = 6'b000100,
        S_QUAD  = 6'b001000,
        S_YEAR  = 6'b010000,
        S_MONTH = 6'b100000
    } t_state;

    t_state               r_state, n_state;
    logic [STEP_BITS-1:0] r_step,  n_step;
    logic                 r_out_valid, n_out_valid;
    logic                 out_busy;

    assign out_busy = r_out_valid && !i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd.op    = OP_NOP;
        o_cmd.step  = r_step;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_ERA;
                    n_step   = STEP_BITS'(ERA_STEPS - 1);
                end
            end
            S_ERA: begin
                o_cmd.op = OP_ERA;
                if (r_step == '0) begin
                    n_state = S_CENT;
                end else begin
                    n_step = r_step - STEP_BITS'(1);
                end
            end
            S_CENT: begin
                o_cmd.op = OP_CENT;
                n_state  = S_QUAD;
                n_step   = STEP_BITS'(QUAD_STEPS - 1);
            end
            S_QUAD: begin
                o_cmd.op = OP_QUAD;
                if (r_step == '0) begin
                    n_state = S_YEAR;
                end else begin
                    n_step = r_step - STEP_BITS'(1);
                end
            end
            S_YEAR: begin
                o_cmd.op = OP_YEAR;
                n_state  = S_MONTH;
            end
            S_MONTH: begin
                // hold until the output register is free
                if (!out_busy) begin
                    o_cmd.op    = OP_MONTH;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTH
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("controller state not one-hot");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=>
            (r_state == S_ERA && r_step == STEP_BITS'(ERA_STEPS - 1)))
        else $error("accepted word did not start era reduction");

    a_era_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ERA) |-> (r_step <= STEP_BITS'(ERA_STEPS - 1)))
        else $error("era step out of range");

    a_month_writes_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MONTH && !out_busy) |=> (r_out_valid && r_state == S_IDLE))
        else $error("result word not posted after month step");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_MONTH) |-> !out_busy)
        else $error("pending result word overwritten");
`endif

endmodule

### sv/days_to_calendar_date.sv
// ----------------------------------------------------------------------------
// days_to_calendar_date: day count since 1970-01-01 to Gregorian date
// Iterative converter: controller sequences a remainder/year datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one word: i_day_count,
//   days since 1970-01-01. Output channel (o_out_valid / i_out_ready)
//   returns one word per input: o_year, o_month (1 = January) and
//   o_day_of_month (1 based), proleptic Gregorian calendar.
//   One word is reduced at a time in the shared remainder register: the
//   accept step, 4 restoring steps over 400-year eras, one century step,
//   5 restoring steps over 4-year blocks, one year step and one month step;
//   the next word is taken only once the month step is done.
//   The result sits in an output register, so the next word is taken while
//   the previous result waits. If the receiver stalls long enough, the
//   month step holds until the output register is taken.
//   Reset (i_rst_n low, synchronous) returns the controller to idle and
//   drops any pending result; no clearing pass is needed.
// ----------------------------------------------------------------------------
module days_to_calendar_date (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [dtcd_pkg::DAY_BITS-1:0]   i_day_count,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [dtcd_pkg::YEAR_BITS-1:0]  o_year,
    output logic [dtcd_pkg::MONTH_BITS-1:0] o_month,
    output logic [dtcd_pkg::DOM_BITS-1:0]   o_day_of_month
);
    import dtcd_pkg::*;

    t_dp_cmd cmd;

    dtcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    dtcd_datapath u_datapath (
        .i_clk          (i_clk),
        .i_cmd          (cmd),
        .i_day_count    (i_day_count),
        .o_year         (o_year),
        .o_month        (o_month),
        .o_day_of_month (o_day_of_month)
    );

endmodule

### tb/tb_days_to_calendar_date.sv
// ----------------------------------------------------------------------------
// tb_days_to_calendar_date: self-checking bench for the day-count converter
// Feeds day counts through the valid/ready input channel and compares every
// returned date against a calendar model kept in a small scoreboard. Phases
// vary sender gaps and receiver stalls, including a long receiver hold.
// ----------------------------------------------------------------------------
module tb_days_to_calendar_date;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DB          = dtcd_pkg::DAY_BITS;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;
    localparam int unsigned EPOCH_YEAR = 1970;
    localparam int MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef struct packed {
        logic [dtcd_pkg::YEAR_BITS-1:0]  year;
        logic [dtcd_pkg::MONTH_BITS-1:0] month;
        logic [dtcd_pkg::DOM_BITS-1:0]   dom;
    } t_cal_date;

    class t_date_scoreboard;
        t_cal_date pending_dates[$];
        int        mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        static function bit has_leap_day(int unsigned yr);
            return ((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0;
        endfunction

        static function t_cal_date civil_date_of(logic [DB-1:0] days);
            int unsigned left;
            int unsigned yr;
            int unsigned mo;
            int unsigned span;
            t_cal_date   d;
            left = 32'(days);
            // strip whole 400-year eras first
            yr   = EPOCH_YEAR + dtcd_pkg::YEARS_PER_ERA * (left / dtcd_pkg::DAYS_PER_ERA);
            left = left % dtcd_pkg::DAYS_PER_ERA;
            span = has_leap_day(yr) ? 366 : 365;
            while (left >= span) begin
                left = left - span;
                yr   = yr + 1;
                span = has_leap_day(yr) ? 366 : 365;
            end
            mo = 1;
            span = MONTH_LEN[0];
            while (left >= span) begin
                left = left - span;
                mo   = mo + 1;
                span = MONTH_LEN[mo-1] + ((mo == 2 && has_leap_day(yr)) ? 1 : 0);
            end
            d.year  = yr[dtcd_pkg::YEAR_BITS-1:0];
            d.month = mo[dtcd_pkg::MONTH_BITS-1:0];
            d.dom   = 5'(left + 1);
            return d;
        endfunction

        function void note_day_count(logic [DB-1:0] days);
            pending_dates.push_back(civil_date_of(days));
        endfunction

        function void report(string what, t_cal_date want, t_cal_date got);
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%s: expected %0d-%0d-%0d, got %0d-%0d-%0d", what,
                         want.year, want.month, want.dom, got.year, got.month, got.dom);
        endfunction

        function void check_date(logic [dtcd_pkg::YEAR_BITS-1:0] year,
                                 logic [dtcd_pkg::MONTH_BITS-1:0] month,
                                 logic [dtcd_pkg::DOM_BITS-1:0] dom);
            t_cal_date got;
            t_cal_date want;
            got.year  = year;
            got.month = month;
            got.dom   = dom;
            if (pending_dates.size() == 0) begin
                report("unexpected date word", '0, got);
            end else begin
                want = pending_dates.pop_front();
                if (got !== want)
                    report("date mismatch", want, got);
            end
        endfunction

        function int outstanding();
            return pending_dates.size();
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_ready;
    logic [DB-1:0]                   i_day_count;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    logic [dtcd_pkg::YEAR_BITS-1:0]  o_year;
    logic [dtcd_pkg::MONTH_BITS-1:0] o_month;
    logic [dtcd_pkg::DOM_BITS-1:0]   o_day_of_month;

    t_date_scoreboard sb;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int hold_seen      = 0;
    int hold_left      = 0;

    days_to_calendar_date u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_day_count    (i_day_count),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_year         (o_year),
        .o_month        (o_month),
        .o_day_of_month (o_day_of_month)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // receiver: a requested hold takes priority over random stalls
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_left = hold_req;
            hold_seen = hold_req;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_date(o_year, o_month, o_day_of_month);
    end

    initial begin
        for (int n = 0; n < CYCLE_LIMIT; n++)
            @(posedge i_clk);
        $display("days_to_calendar_date regression: fail");
        $finish;
    end

    function automatic logic [DB-1:0] pick_day_count();
        int unsigned base;
        unique case ($urandom_range(3))
            0, 1: return DB'($urandom_range((1 << DB) - 1));
            2:    return DB'($urandom_range(30000));
            default: begin
                // land near an era boundary, where year stepping restarts
                base = $urandom_range(7) * dtcd_pkg::DAYS_PER_ERA + 800;
                return DB'(base - $urandom_range(1600));
            end
        endcase
    endfunction

    task automatic send_day(input logic [DB-1:0] days);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_day_count <= days;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_day_count(days);
    endtask

    task automatic finish_dates();
        i_in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int k = 0; k < count; k++)
            send_day(pick_day_count());
        finish_dates();
    endtask

    initial begin
        int unsigned directed_days [$];
        sb = new();
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_day_count <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // epoch, year ends, leap days in 1972/2000/2400, no leap day in 2100,
        // era boundary, alternating bit patterns and the top of the range
        directed_days = '{0, 1, 58, 59, 364, 365, 729, 730, 789, 790, 1095, 1096,
                          10957, 11016, 11017, 47540, 47541, 146096, 146097,
                          157113, 20'hAAAAA, 20'h55555, (1 << DB) - 2, (1 << DB) - 1};
        foreach (directed_days[k])
            send_day(DB'(directed_days[k]));
        finish_dates();

        run_phase(0, 0, 150);
        run_phase(88, 0, 100);
        run_phase(0, 88, 100);
        run_phase(24, 24, 150);

        // hold the receiver so the converter backs up into its input
        hold_req = 300;
        run_phase(0, 0, 60);

        repeat (30) @(posedge i_clk);
        if (sb.mismatch_count == 0 && sb.outstanding() == 0)
            $display("days_to_calendar_date regression: pass");
        else
            $display("days_to_calendar_date regression: fail");
        $finish;
    end
endmodule

### files.f
sv/dtcd_pkg.sv
sv/dtcd_datapath.sv
sv/dtcd_ctrl.sv
sv/days_to_calendar_date.sv
tb/tb_days_to_calendar_date.sv
